@@ rtl/core/pcbs_pkg.sv @@
`default_nettype none

package pcbs_pkg;

    // result status codes
    localparam logic [2:0] ST_ORDERED  = 3'd0;
    localparam logic [2:0] ST_PARKED   = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_RELEASED = 3'd5;

    typedef struct packed {
        logic clr_step;     // write one zero entry of the expected table
        logic load;         // capture the input word
        logic look;         // capture table read, compare park keys
        logic emit_single;  // emit non-ordered result (and park if due)
        logic order;        // order the in-sequence batch into the pending result
        logic search;       // look up the next expected number in the park store
        logic emit_pend;    // emit pending result, take matched slot
        logic unpark;       // order the unparked batch into the pending result
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic eq;
        logic any_match;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pcbs_if.sv @@
`default_nettype none

interface pcbs_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  client;
    logic [31:0] batch_number;
    logic [15:0] message_count;
    logic [15:0] batch_tag;

    modport source (output valid, output client, output batch_number,
                    output message_count, output batch_tag, input ready);
    modport sink   (input valid, input client, input batch_number,
                    input message_count, input batch_tag, output ready);
endinterface

interface pcbs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] out_tag;
    logic [47:0] start_order;
    logic [15:0] export_index;
    logic        last;

    modport source (output valid, output status, output out_tag, output start_order,
                    output export_index, output last, input ready);
    modport sink   (input valid, input status, input out_tag, input start_order,
                    input export_index, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pcbs_ram.sv @@
`default_nettype none

module pcbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/pcbs_ctrl.sv @@
`default_nettype none

module pcbs_ctrl
    import pcbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SRCH   = 3'd4;
    localparam logic [2:0] S_SEL    = 3'd5;
    localparam logic [2:0] S_REL    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.eq)
                begin
                    cmd.order  = 1'b1;
                    state_next = S_SRCH;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SRCH:
            begin
                cmd.search = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                // pending word waits here until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit_pend = 1'b1;
                    state_next    = stat.any_match ? S_REL : S_IDLE;
                end
            end
            S_REL:
            begin
                cmd.unpark = 1'b1;
                state_next = S_SRCH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pcbs_datapath.sv @@
`default_nettype none

module pcbs_datapath
    import pcbs_pkg::*;
#(
    parameter int CLIENTS    = 256,
    parameter int PARK_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    input  wire logic [7:0]  in_client,
    input  wire logic [31:0] in_batch_number,
    input  wire logic [15:0] in_message_count,
    input  wire logic [15:0] in_batch_tag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_status,
    output logic [15:0]      out_tag,
    output logic [47:0]      out_start_order,
    output logic [15:0]      out_export_index,
    output logic             out_last
);

    localparam int AW = $clog2(CLIENTS);
    localparam int SW = (PARK_SLOTS > 1) ? $clog2(PARK_SLOTS) : 1;

    // client mod CLIENTS by shifted compare-subtract, eight steps
    function automatic logic [7:0] client_wrap(input logic [7:0] c);
        logic [31:0] r;
        r = {24'd0, c};
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= (32'(CLIENTS) << k))
            begin
                r = r - (32'(CLIENTS) << k);
            end
        end
        return r[7:0];
    endfunction

    function automatic logic [SW-1:0] first_set(input logic [PARK_SLOTS-1:0] v);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = PARK_SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SW'(i);
            end
        end
        return idx;
    endfunction

    logic [7:0]  client_reg;
    logic [31:0] number_reg;
    logic [15:0] count_reg;
    logic [15:0] tag_reg;
    logic [31:0] expect_reg;
    logic [47:0] global_reg;
    logic [15:0] export_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [PARK_SLOTS-1:0] park_valid_reg;
    logic [39:0]           park_key_reg [PARK_SLOTS];
    logic [PARK_SLOTS-1:0] match_vec_reg;
    logic [PARK_SLOTS-1:0] match_next;

    logic [2:0]  pend_status_reg;
    logic [15:0] pend_tag_reg;
    logic [47:0] pend_order_reg;
    logic [15:0] pend_export_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [15:0] out_tag_reg;
    logic [47:0] out_order_reg;
    logic [15:0] out_export_reg;
    logic        out_last_reg;

    logic          exp_we;
    logic [AW-1:0] exp_waddr;
    logic [31:0]   exp_wdata;
    logic [AW-1:0] exp_raddr;
    logic [31:0]   exp_rdata;

    logic          park_we;
    logic [SW-1:0] park_slot;
    logic [31:0]   park_rdata;

    logic [31:0]   key_num;
    logic          any_match;
    logic          any_free;
    logic [SW-1:0] match_slot;
    logic [SW-1:0] free_slot;
    logic          is_empty;
    logic          is_lt;
    logic [2:0]    single_status;
    logic          take_slot;
    logic          out_free;

    assign any_match  = |match_vec_reg;
    assign any_free   = ~(&park_valid_reg);
    assign match_slot = first_set(match_vec_reg);
    assign free_slot  = first_set(~park_valid_reg);
    assign park_slot  = any_match ? match_slot : free_slot;

    assign is_empty = (count_reg == 16'd0);
    assign is_lt    = (number_reg < expect_reg);

    always_comb
    begin
        if (is_empty)
        begin
            single_status = ST_EMPTY;
        end
        else if (is_lt)
        begin
            single_status = ST_DUP;
        end
        else if (any_match || any_free)
        begin
            single_status = ST_PARKED;
        end
        else
        begin
            single_status = ST_FULL;
        end
    end

    assign park_we   = cmd.emit_single && (single_status == ST_PARKED);
    assign take_slot = cmd.emit_pend && any_match;
    assign out_free  = !out_valid_reg || out_ready;

    assign stat.clr_done  = (clr_cnt_reg == AW'(CLIENTS - 1));
    assign stat.eq        = !is_empty && (number_reg == expect_reg);
    assign stat.any_match = any_match;
    assign stat.out_free  = out_free;

    // expected-number table
    assign exp_raddr = AW'(client_wrap(in_client));
    assign exp_we    = cmd.clr_step || cmd.order || take_slot;
    assign exp_waddr = cmd.clr_step ? clr_cnt_reg : AW'(client_reg);
    assign exp_wdata = cmd.clr_step ? 32'd0 : expect_reg + 32'd1;

    pcbs_ram #(
        .WIDTH (32),
        .DEPTH (CLIENTS)
    ) u_exp_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (exp_raddr),
        .rdata (exp_rdata)
    );

    // parked {message_count, batch_tag}, read at the matched slot
    pcbs_ram #(
        .WIDTH (32),
        .DEPTH (PARK_SLOTS)
    ) u_park_ram (
        .clk   (clk),
        .we    (park_we),
        .waddr (park_slot),
        .wdata ({count_reg, tag_reg}),
        .raddr (match_slot),
        .rdata (park_rdata)
    );

    assign key_num = cmd.look ? number_reg : expect_reg;

    always_comb
    begin
        for (int i = 0; i < PARK_SLOTS; i++)
        begin
            match_next[i] = park_valid_reg[i] && (park_key_reg[i] == {client_reg, key_num});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            park_valid_reg <= '0;
            global_reg     <= '0;
            export_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (park_we)
            begin
                park_valid_reg[park_slot] <= 1'b1;
            end
            if (take_slot)
            begin
                park_valid_reg[match_slot] <= 1'b0;
            end
            if (cmd.order)
            begin
                global_reg <= global_reg + 48'(count_reg);
                export_reg <= export_reg + 16'd1;
            end
            else if (cmd.unpark)
            begin
                global_reg <= global_reg + 48'(park_rdata[31:16]);
                export_reg <= export_reg + 16'd1;
            end
            if (cmd.emit_single || cmd.emit_pend)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            client_reg <= client_wrap(in_client);
            number_reg <= in_batch_number;
            count_reg  <= in_message_count;
            tag_reg    <= in_batch_tag;
        end
        if (cmd.look)
        begin
            expect_reg <= exp_rdata;
        end
        else if (cmd.order || take_slot)
        begin
            expect_reg <= expect_reg + 32'd1;
        end
        if (cmd.look || cmd.search)
        begin
            match_vec_reg <= match_next;
        end
        if (park_we)
        begin
            park_key_reg[park_slot] <= {client_reg, number_reg};
        end
        if (cmd.order)
        begin
            pend_status_reg <= ST_ORDERED;
            pend_tag_reg    <= tag_reg;
            pend_order_reg  <= global_reg;
            pend_export_reg <= export_reg;
        end
        else if (cmd.unpark)
        begin
            pend_status_reg <= ST_RELEASED;
            pend_tag_reg    <= park_rdata[15:0];
            pend_order_reg  <= global_reg;
            pend_export_reg <= export_reg;
        end
        if (cmd.emit_single)
        begin
            out_status_reg <= single_status;
            out_tag_reg    <= tag_reg;
            out_order_reg  <= 48'd0;
            out_export_reg <= 16'd0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_pend)
        begin
            out_status_reg <= pend_status_reg;
            out_tag_reg    <= pend_tag_reg;
            out_order_reg  <= pend_order_reg;
            out_export_reg <= pend_export_reg;
            out_last_reg   <= !any_match;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_tag          = out_tag_reg;
    assign out_start_order  = out_order_reg;
    assign out_export_index = out_export_reg;
    assign out_last         = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/per_client_batch_sequencer.sv @@
// Flow: a duplicate, empty, parked or park-full batch is looked up and decided, and its
// word is loaded once the output register is free; an in-order batch is ordered, then
// searched and selected, and each released batch adds a lookup, select and read step.
// One batch at a time goes through the table read-modify-write and park lookup; the next
// is accepted only after the previous one's last word is loaded. Reset: asynchronous,
// active low; a clearing pass then zeroes the expected-number table, accepting no batch.
`default_nettype none

module per_client_batch_sequencer
    import pcbs_pkg::*;
#(
    parameter int CLIENTS    = 256,
    parameter int PARK_SLOTS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pcbs_in_if.sink     in_ch,
    pcbs_out_if.source  out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign in_ch.ready = in_ready;

    pcbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcbs_datapath #(
        .CLIENTS    (CLIENTS),
        .PARK_SLOTS (PARK_SLOTS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_client        (in_ch.client),
        .in_batch_number  (in_ch.batch_number),
        .in_message_count (in_ch.message_count),
        .in_batch_tag     (in_ch.batch_tag),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_status       (out_ch.status),
        .out_tag          (out_ch.out_tag),
        .out_start_order  (out_ch.start_order),
        .out_export_index (out_ch.export_index),
        .out_last         (out_ch.last)
    );

`ifndef SYNTHESIS
    // one batch in flight: no accept directly after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("batch accepted while previous still in work");

    // a word is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_single || cmd.emit_pend) |-> stat.out_free)
        else $error("output word overwritten");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

    // a release always follows a non-final word
    a_release_after_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.unpark |-> $past(cmd.emit_pend && stat.any_match))
        else $error("release without matched slot");
`endif

endmodule

`default_nettype wire

@@ sim/per_client_batch_sequencer_test.sv @@
`timescale 1ns / 1ps

module per_client_batch_sequencer_test
    import pcbs_pkg::*;
();

    localparam int CLIENTS      = 256;
    localparam int PARK_SLOTS   = 16;
    localparam int RANDOM_ITEMS = 330;
    localparam int SINK_HOLD    = 400;
    localparam int SETTLE       = 80;
    localparam int RUN_LIMIT    = 1500000;

    typedef struct packed {
        logic [7:0]  client;
        logic [31:0] number;
        logic [15:0] count;
        logic [15:0] tag;
    } batch_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] tag;
        logic [47:0] order;
        logic [15:0] slot;
        logic        last;
    } batch_result_t;

    typedef struct {
        batch_t        b;
        bit            typed;
        batch_result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pcbs_in_if  in_ch ();
    pcbs_out_if out_ch ();

    per_client_batch_sequencer #(
        .CLIENTS    (CLIENTS),
        .PARK_SLOTS (PARK_SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predicted sequencer state
    logic [31:0] next_number [CLIENTS];
    logic [47:0] msg_order;
    logic [15:0] export_slot;
    bit          held_valid  [PARK_SLOTS];
    logic [7:0]  held_client [PARK_SLOTS];
    logic [31:0] held_number [PARK_SLOTS];
    logic [15:0] held_count  [PARK_SLOTS];
    logic [15:0] held_tag    [PARK_SLOTS];

    batch_result_t outcomes [$];
    logic [7:0]    client_pool [8];

    int errors = 0;
    int cycle_count = 0;
    bit hold_sink = 1'b0;
    bit steady = 1'b0;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want, input logic [15:0] tag);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h (tag %0h)", name, got, want, tag));
    endtask

    function automatic void sequence_batch(input batch_t b);
        batch_result_t r;
        int c;
        int n;
        int slot;
        bit found;
        logic [31:0] want;
        c = b.client % CLIENTS;
        want = next_number[c];
        r = '0;
        r.tag = b.tag;
        if (b.count != 0 && b.number == want) begin
            r.status = ST_ORDERED;
            r.order = msg_order;
            r.slot = export_slot;
            msg_order += b.count;
            export_slot++;
            next_number[c] = want + 32'd1;
            outcomes.push_back(r);
            n = 1;
            found = 1'b1;
            // drain parked batches of this client that are now due
            while (found && n < 1 + PARK_SLOTS) begin
                found = 1'b0;
                for (int i = 0; i < PARK_SLOTS; i++) begin
                    if (!found && held_valid[i] && held_client[i] == c
                        && held_number[i] == next_number[c]) begin
                        held_valid[i] = 1'b0;
                        r.status = ST_RELEASED;
                        r.tag = held_tag[i];
                        r.order = msg_order;
                        r.slot = export_slot;
                        msg_order += held_count[i];
                        export_slot++;
                        next_number[c] = next_number[c] + 32'd1;
                        outcomes.push_back(r);
                        n++;
                        found = 1'b1;
                    end
                end
            end
        end
        else begin
            if (b.count == 0)
                r.status = ST_EMPTY;
            else if (b.number < want)
                r.status = ST_DUP;
            else begin
                slot = -1;
                for (int i = 0; i < PARK_SLOTS; i++)
                    if (slot < 0 && held_valid[i] && held_client[i] == c
                        && held_number[i] == b.number)
                        slot = i;
                for (int i = 0; i < PARK_SLOTS; i++)
                    if (slot < 0 && !held_valid[i])
                        slot = i;
                if (slot < 0)
                    r.status = ST_FULL;
                else begin
                    held_valid[slot] = 1'b1;
                    held_client[slot] = 8'(c);
                    held_number[slot] = b.number;
                    held_count[slot] = b.count;
                    held_tag[slot] = b.tag;
                    r.status = ST_PARKED;
                end
            end
            outcomes.push_back(r);
        end
        r = outcomes.pop_back();
        r.last = 1'b1;
        outcomes.push_back(r);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic stim_row_t stim_entry(input logic [7:0] c, input logic [31:0] n,
                                             input logic [15:0] cnt, input logic [15:0] tag,
                                             input bit typed, input logic [2:0] st,
                                             input logic [47:0] ord, input logic [15:0] slot);
        stim_row_t e;
        e.b = '{client: c, number: n, count: cnt, tag: tag};
        e.typed = typed;
        e.want = '{status: st, tag: tag, order: ord, slot: slot, last: 1'b1};
        return e;
    endfunction

    function automatic batch_t random_batch();
        batch_t b;
        int sel;
        int k;
        int idx;
        logic [31:0] e;
        sel = $urandom_range(0, 99);
        b.tag = 16'($urandom);
        b.count = ($urandom_range(0, 99) < 3) ? 16'd0 : 16'($urandom_range(1, 65535));
        b.client = client_pool[$urandom_range(0, 7)];
        e = next_number[b.client % CLIENTS];
        if (sel < 8) begin
            // noise: any client, mostly number zero, sometimes far out
            b.client = 8'($urandom);
            b.number = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'd0;
            if ($urandom_range(0, 9) == 0)
                b.count = 16'd0;
            return b;
        end
        if (sel < 16) begin
            // resend a batch that is already parked
            k = $urandom_range(0, PARK_SLOTS - 1);
            for (int j = 0; j < PARK_SLOTS; j++) begin
                idx = (k + j) % PARK_SLOTS;
                if (held_valid[idx]) begin
                    b.client = held_client[idx];
                    b.number = held_number[idx];
                    return b;
                end
            end
        end
        k = $urandom_range(0, 99);
        if (k < 55)
            b.number = e;
        else if (k < 90 || e == 0)
            b.number = e + 32'($urandom_range(1, 5));
        else
            b.number = 32'($urandom_range(0, e - 1));
        return b;
    endfunction

    task automatic send_batch(input batch_t b, input bit typed, input batch_result_t want);
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.client <= b.client;
        in_ch.batch_number <= b.number;
        in_ch.message_count <= b.count;
        in_ch.batch_tag <= b.tag;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sequence_batch(b);
        if (typed) begin
            void'(outcomes.pop_back());
            outcomes.push_back(want);
        end
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            in_ch.client <= 8'($urandom);
            in_ch.batch_number <= 32'($urandom);
            in_ch.message_count <= 16'($urandom);
            in_ch.batch_tag <= 16'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    initial
    begin : run_limit
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : sink_side
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                // long back-pressure while the sender keeps offering
                out_ch.ready <= 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
                hold_sink = 1'b0;
            end
            else if (steady)
                out_ch.ready <= 1'b1;
            else begin
                gap = idle_len();
                if (gap == 0)
                    out_ch.ready <= 1'b1;
                else begin
                    out_ch.ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        batch_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (outcomes.size() == 0)
                report_mismatch($sformatf("unexpected word, status %0d tag %0h",
                                          out_ch.status, out_ch.out_tag));
            else begin
                want = outcomes.pop_front();
                check_field("status", 48'(out_ch.status), 48'(want.status), want.tag);
                check_field("out_tag", 48'(out_ch.out_tag), 48'(want.tag), want.tag);
                check_field("start_order", out_ch.start_order, want.order, want.tag);
                check_field("export_index", 48'(out_ch.export_index), 48'(want.slot),
                            want.tag);
                check_field("last", 48'(out_ch.last), 48'(want.last), want.tag);
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t rows [$];
        batch_t b;
        int busy;
        bit hold_sent;
        bit drained;

        in_ch.valid = 1'b0;
        in_ch.client = '0;
        in_ch.batch_number = '0;
        in_ch.message_count = '0;
        in_ch.batch_tag = '0;
        rst_n = 1'b0;

        for (int i = 0; i < CLIENTS; i++)
            next_number[i] = '0;
        for (int i = 0; i < PARK_SLOTS; i++)
            held_valid[i] = 1'b0;
        msg_order = '0;
        export_slot = '0;
        for (int i = 0; i < 8; i++)
            client_pool[i] = 8'($urandom);

        // directed: extremes, every status, store full, longest release chain, re-park
        rows.push_back(stim_entry(8'd0, 32'd0, 16'hFFFF, 16'h0000, 1, ST_ORDERED, 0, 0));
        rows.push_back(stim_entry(8'd0, 32'd0, 16'h0001, 16'hFFFF, 1, ST_DUP, 0, 0));
        rows.push_back(stim_entry(8'd255, 32'd0, 16'h0000, 16'h1234, 1, ST_EMPTY, 0, 0));
        for (int i = 1; i <= PARK_SLOTS; i++)
            rows.push_back(stim_entry(8'd1, 32'(i), 16'(16'h1000 + i), 16'(16'h0100 + i),
                                      1, ST_PARKED, 0, 0));
        rows.push_back(stim_entry(8'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'hBEEF, 1, ST_FULL, 0, 0));
        rows.push_back(stim_entry(8'd1, 32'd0, 16'h8000, 16'h0200, 0, ST_ORDERED, 0, 0));
        rows.push_back(stim_entry(8'd255, 32'hFFFF_FFFF, 16'd5, 16'hAAAA, 1, ST_PARKED, 0, 0));
        rows.push_back(stim_entry(8'd255, 32'hFFFF_FFFF, 16'd7, 16'h5555, 1, ST_PARKED, 0, 0));
        rows.push_back(stim_entry(8'd255, 32'd0, 16'd3, 16'h0300, 0, ST_ORDERED, 0, 0));
        rows.push_back(stim_entry(8'd2, 32'd0, 16'd1, 16'h0400, 0, ST_ORDERED, 0, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_batch(rows[i].b, rows[i].typed, rows[i].want);
            idle_sender(idle_len());
        end

        busy = 0;
        hold_sent = 1'b0;
        drained = 1'b0;
        while (busy < RANDOM_ITEMS) begin
            steady = (busy >= 150 && busy < 200);
            if (busy == 60 && !hold_sent) begin
                hold_sink = 1'b1;
                hold_sent = 1'b1;
            end
            if (busy == 250 && !drained) begin
                idle_sender(1);
                while (outcomes.size() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            b = random_batch();
            send_batch(b, 1'b0, '0);
            if (b.count != 0)
                busy++;
            if (!steady && !hold_sink)
                idle_sender(idle_len());
        end
        steady = 1'b0;
        idle_sender(1);

        while (outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (outcomes.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", outcomes.size()));

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
